// ===== rtl/agx_pkg.sv =====
// Shared types, phase and status codes for the AgentX Get request parser.
package agx_pkg;

  localparam int MAX_ITEMS = 6;
  localparam int CNT_W     = 3;

  localparam logic [2:0] PH_START    = 3'd0;
  localparam logic [2:0] PH_CTX_LEN  = 3'd1;
  localparam logic [2:0] PH_CTX_BODY = 3'd2;
  localparam logic [2:0] PH_OID_HDR  = 3'd3;
  localparam logic [2:0] PH_OID_SUB  = 3'd4;

  localparam logic [1:0] ST_SUBID = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_pdu;
  } in_t;

  typedef struct packed {
    logic [31:0] subid;
    logic        oid_last;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  byte_position;
    logic [23:0] word_accumulator;
    logic [7:0]  subids_remaining;
    logic [7:0]  prefix_byte;
    logic        parsing_start_oid;
    logic [33:0] context_bytes_left;
  } state_t;

  function automatic out_t make_item(logic [31:0] subid, logic last, logic [1:0] st);
    out_t item;
    item.subid    = subid;
    item.oid_last = last;
    item.status   = st;
    return item;
  endfunction

endpackage

// ===== rtl/agentx_get_request_parser.sv =====
// AgentX Get PDU search-range parser top level, one payload byte per request.
// Latency: first result item is offered the cycle after the byte is accepted.
// Throughput, while out_ready is high: one byte per cycle while each byte gives at
// most one item; a byte giving several items (prefixed OID header, end of PDU) holds
// input until the result bank has nearly drained, one item per cycle on the output.
// Reset (synchronous): parser at start of PDU, result bank empty, ctx_flag 0.
module agentx_get_request_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  agx_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output agx_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          context_present
);

  agx_pkg::state_t                        state;
  agx_pkg::state_t                        state_next;
  agx_pkg::out_t [agx_pkg::MAX_ITEMS-1:0] items;
  logic [agx_pkg::CNT_W-1:0]              item_count;
  logic                                   ctx_flag;
  logic                                   accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_flag <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      ctx_flag <= context_present;
    end
  end

  agx_parse_step u_step (
    .state           (state),
    .context_present (ctx_flag),
    .req             (in_data),
    .state_next      (state_next),
    .items           (items),
    .item_count      (item_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase              <= agx_pkg::PH_START;
      state.byte_position      <= 2'd0;
      state.word_accumulator   <= 24'd0;
      state.subids_remaining   <= 8'd0;
      state.prefix_byte        <= 8'd0;
      state.parsing_start_oid  <= 1'b1;
      state.context_bytes_left <= 34'd0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  agx_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .load_items (items),
    .load_count (item_count),
    .space      (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

`ifndef ASSERT_OFF
  a_eop_gives_item: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.end_of_pdu |=> out_valid)
    else $error("end of PDU gave no result item");

  a_eop_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.end_of_pdu |=> state.phase == agx_pkg::PH_START)
    else $error("parser not back at start after end of PDU");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  a_start_aligned: assert property (@(posedge clk) disable iff (rst)
    state.phase == agx_pkg::PH_START |-> state.byte_position == 2'd0)
    else $error("byte position not cleared at start of PDU");
`endif

endmodule

// ===== rtl/agx_parse_step.sv =====
// Per-byte parser update: next state and the result items one request produces.
module agx_parse_step (
  input  agx_pkg::state_t                        state,
  input  logic                                   context_present,
  input  agx_pkg::in_t                           req,
  output agx_pkg::state_t                        state_next,
  output agx_pkg::out_t [agx_pkg::MAX_ITEMS-1:0] items,
  output logic [agx_pkg::CNT_W-1:0]              item_count
);

  always_comb begin
    agx_pkg::state_t          s;
    logic [31:0]              word;
    logic [33:0]              padded;
    logic [agx_pkg::CNT_W-1:0] n;
    logic                     ok;

    s     = state;
    items = '0;
    n     = '0;
    ok    = 1'b0;

    // first byte of a PDU picks up the context flag
    if (s.phase == agx_pkg::PH_START) begin
      s.phase             = context_present ? agx_pkg::PH_CTX_LEN : agx_pkg::PH_OID_HDR;
      s.byte_position     = 2'd0;
      s.word_accumulator  = 24'd0;
      s.parsing_start_oid = 1'b1;
    end

    word   = {s.word_accumulator, req.data_byte};
    padded = ({2'b00, word} + 34'd3) & ~34'd3;

    unique case (s.phase)
      agx_pkg::PH_CTX_LEN: begin
        if (s.byte_position != 2'd3) begin
          s.word_accumulator = word[23:0];
          s.byte_position    = s.byte_position + 2'd1;
        end else begin
          s.byte_position    = 2'd0;
          s.word_accumulator = 24'd0;
          if (padded == 34'd0) begin
            s.phase = agx_pkg::PH_OID_HDR;
          end else begin
            s.context_bytes_left = padded;
            s.phase              = agx_pkg::PH_CTX_BODY;
          end
        end
      end
      agx_pkg::PH_CTX_BODY: begin
        if (s.context_bytes_left <= 34'd1) begin
          s.context_bytes_left = 34'd0;
          s.phase              = agx_pkg::PH_OID_HDR;
          s.byte_position      = 2'd0;
        end else begin
          s.context_bytes_left = s.context_bytes_left - 34'd1;
        end
      end
      agx_pkg::PH_OID_HDR: begin
        if (s.byte_position == 2'd0) s.subids_remaining = req.data_byte;
        if (s.byte_position == 2'd1) s.prefix_byte = req.data_byte;
        if (s.byte_position != 2'd3) begin
          s.byte_position = s.byte_position + 2'd1;
        end else begin
          s.byte_position    = 2'd0;
          s.word_accumulator = 24'd0;
          if (s.parsing_start_oid) begin
            if (s.prefix_byte != 8'd0) begin
              // internet prefix 1.3.6.1.<prefix>
              items[0] = agx_pkg::make_item(32'd1, 1'b0, agx_pkg::ST_SUBID);
              items[1] = agx_pkg::make_item(32'd3, 1'b0, agx_pkg::ST_SUBID);
              items[2] = agx_pkg::make_item(32'd6, 1'b0, agx_pkg::ST_SUBID);
              items[3] = agx_pkg::make_item(32'd1, 1'b0, agx_pkg::ST_SUBID);
              items[4] = agx_pkg::make_item({24'd0, s.prefix_byte},
                                            s.subids_remaining == 8'd0, agx_pkg::ST_SUBID);
              n = 3'd5;
            end else if (s.subids_remaining == 8'd0) begin
              items[0] = agx_pkg::make_item(32'd0, 1'b1, agx_pkg::ST_EMPTY);
              n = 3'd1;
            end
          end
          if (s.subids_remaining == 8'd0) begin
            s.parsing_start_oid = ~s.parsing_start_oid;
            s.phase             = agx_pkg::PH_OID_HDR;
          end else begin
            s.phase = agx_pkg::PH_OID_SUB;
          end
        end
      end
      agx_pkg::PH_OID_SUB: begin
        if (s.byte_position != 2'd3) begin
          s.word_accumulator = word[23:0];
          s.byte_position    = s.byte_position + 2'd1;
        end else begin
          s.byte_position    = 2'd0;
          s.word_accumulator = 24'd0;
          if (s.subids_remaining != 8'd0) s.subids_remaining = s.subids_remaining - 8'd1;
          if (s.parsing_start_oid) begin
            items[0] = agx_pkg::make_item(word, s.subids_remaining == 8'd0, agx_pkg::ST_SUBID);
            n = 3'd1;
          end
          if (s.subids_remaining == 8'd0) begin
            s.parsing_start_oid = ~s.parsing_start_oid;
            s.phase             = agx_pkg::PH_OID_HDR;
          end
        end
      end
      default: begin
        s.phase = agx_pkg::PH_START;
      end
    endcase

    if (req.end_of_pdu) begin
      // done only on a whole range boundary, back at a start OID header
      ok = (s.phase == agx_pkg::PH_OID_HDR) && (s.byte_position == 2'd0) &&
           s.parsing_start_oid;
      items[n] = agx_pkg::make_item(32'd0, 1'b0, ok ? agx_pkg::ST_DONE : agx_pkg::ST_TRUNC);
      n = n + 3'd1;
      s.phase              = agx_pkg::PH_START;
      s.byte_position      = 2'd0;
      s.word_accumulator   = 24'd0;
      s.subids_remaining   = 8'd0;
      s.prefix_byte        = 8'd0;
      s.parsing_start_oid  = 1'b1;
      s.context_bytes_left = 34'd0;
    end

    state_next = s;
    item_count = n;
  end

endmodule

// ===== rtl/agx_out_queue.sv =====
// Result register bank: holds one request's items, emits one per cycle on out_ready.
module agx_out_queue (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   load,
  input  agx_pkg::out_t [agx_pkg::MAX_ITEMS-1:0] load_items,
  input  logic [agx_pkg::CNT_W-1:0]              load_count,
  output logic                                   space,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output agx_pkg::out_t                          out_data
);

  agx_pkg::out_t [agx_pkg::MAX_ITEMS-1:0] slots;
  logic [agx_pkg::CNT_W-1:0]              count;
  logic                                   pop;

  assign out_valid = (count != '0);
  assign out_data  = slots[0];
  assign pop       = out_valid && out_ready;
  // room for a new request once the last held item leaves this cycle
  assign space     = (count == '0) || ((count == agx_pkg::CNT_W'(1)) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= load_count;
    end else if (pop) begin
      count <= count - agx_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= load_items;
    end else if (pop) begin
      for (int i = 0; i < agx_pkg::MAX_ITEMS - 1; i++) begin
        slots[i] <= slots[i+1];
      end
    end
  end

endmodule
